// File: design/sdwa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and beat types of the sparse-to-dense weighted average block.
package sdwa_pkg;

	localparam int DENSE_DEPTH   = 64;
	localparam int NUM_VARIABLES = 4;

	localparam int IDX_W  = $clog2(DENSE_DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int SUM_W  = 40;
	localparam int FRAC_W = 16;
	localparam int DVD_W  = SUM_W + FRAC_W;
	localparam int POS_W  = 6;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_RANGE       = 2'd1;
	localparam logic [1:0] ST_ZERO_WEIGHT = 2'd2;

	typedef logic [1:0] cfg_index_t;

	localparam cfg_index_t CFG_DENSE_SIZE = 2'd0;
	localparam cfg_index_t CFG_SEL_VAR    = 2'd1;
	localparam cfg_index_t CFG_FILL       = 2'd2;

	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_EMIT_RD,
		S_EMIT_CHK,
		S_EMIT_DIV
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] entry_index;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [31:0] value_c;
		logic [31:0] value_d;
		logic [31:0] entry_weight;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [31:0]      dense_value;
		logic             untouched;
		logic [1:0]       status;
		logic             last;
	} result_t;

endpackage

// File: design/sdwa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module sdwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/sdwa_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider that produces one quotient bit per cycle.
module sdwa_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sdwa_pkg::DVD_W-1:0] dividend,
	input  logic [sdwa_pkg::SUM_W-1:0] divisor,
	output logic                       done,
	output logic [sdwa_pkg::DVD_W-1:0] quotient
);
	import sdwa_pkg::*;

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [SUM_W:0]    rem_sh;
	logic [SUM_W+1:0]  diff;
	logic              fits;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign fits   = !diff[SUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= STEP_W'(DVD_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == STEP_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: design/sparse_to_dense_weighted_average_top.sv
`timescale 1ns / 1ps
// Top level of the sparse-to-dense weighted average block.
// An item is taken when start is high and busy is low, and one item is worked at a time.
// An add reads the position's sums from the RAM when it is accepted and writes them back
// in S_ADD, where its status beat is also registered for the result ports. An emit walks
// the positions in use: an untouched position is answered from S_EMIT_RD, a touched
// position with a zero weight sum from S_EMIT_CHK, and any other touched position from
// S_EMIT_DIV once the 56-step bit-serial divider is done. Each result beat is shown for
// exactly one cycle with result_valid high, and the receiver must take it then. No clearing
// pass is needed after reset. Configuration writes are taken at any time but must only be
// made while the block is idle.
module sparse_to_dense_weighted_average_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sdwa_pkg::item_t      item,
	output logic                 result_valid,
	output sdwa_pkg::result_t    result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  sdwa_pkg::cfg_index_t cfg_index,
	input  logic [31:0]          cfg_data
);
	import sdwa_pkg::*;

	state_t state_q, state_d;

	logic [6:0]  dense_size_q;
	logic [1:0]  sel_var_q;
	logic [31:0] fill_q;

	logic [CNT_W-1:0]       eff_n;
	logic [IDX_W-1:0]       pos_q;
	logic                   pos_last;
	logic [DENSE_DEPTH-1:0] touched_q;

	logic [IDX_W-1:0] idx_q;
	logic [31:0]      val_q;
	logic [31:0]      wgt_q;
	logic             in_range_q;
	logic             neg_q;
	logic [31:0]      sel_val;

	logic                 accept;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_raddr;
	logic [2*SUM_W-1:0]   ram_wdata;
	logic [2*SUM_W-1:0]   ram_rdata;
	logic [SUM_W-1:0]     old_vs;
	logic [SUM_W-1:0]     old_ws;
	logic [SUM_W:0]       vs_sum;
	logic [SUM_W:0]       ws_sum;
	logic [SUM_W-1:0]     new_vs;
	logic [SUM_W-1:0]     new_ws;
	logic [SUM_W-1:0]     mag;
	logic [DVD_W-1:0]     dividend;
	logic                 div_start;
	logic                 div_done;
	logic [DVD_W-1:0]     quo;
	logic [31:0]          div_val;

	logic    res_load;
	result_t res_d;
	result_t result_q;
	logic    result_valid_q;
	logic    pos_inc;
	logic    marks_clr;
	logic    mark_set;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (dense_size_q == 7'd0) begin
			eff_n = CNT_W'(1);
		end else if (dense_size_q > 7'(DENSE_DEPTH)) begin
			eff_n = CNT_W'(DENSE_DEPTH);
		end else begin
			eff_n = CNT_W'(dense_size_q);
		end
	end

	assign pos_last = ((CNT_W'(pos_q) + CNT_W'(1)) == eff_n);

	always_comb begin
		if ({1'b0, sel_var_q} >= 3'(NUM_VARIABLES)) begin
			sel_val = item.value_a;
		end else begin
			case (sel_var_q)
				2'd0:    sel_val = item.value_a;
				2'd1:    sel_val = item.value_b;
				2'd2:    sel_val = item.value_c;
				2'd3:    sel_val = item.value_d;
				default: sel_val = item.value_a;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dense_size_q <= 7'(DENSE_DEPTH);
			sel_var_q    <= 2'd0;
			fill_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DENSE_SIZE: dense_size_q <= cfg_data[6:0];
				CFG_SEL_VAR:    sel_var_q    <= cfg_data[1:0];
				CFG_FILL:       fill_q       <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q      <= item.entry_index[IDX_W-1:0];
			val_q      <= sel_val;
			wgt_q      <= item.entry_weight;
			in_range_q <= (item.entry_index < 16'(eff_n));
		end
		if (state_q == S_EMIT_CHK) begin
			neg_q <= old_vs[SUM_W-1];
		end
	end

	assign ram_raddr = (state_q == S_IDLE) ? item.entry_index[IDX_W-1:0] : pos_q;

	sdwa_ram #(
		.WIDTH(2 * SUM_W),
		.DEPTH(DENSE_DEPTH)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign old_vs = ram_rdata[2*SUM_W-1:SUM_W];
	assign old_ws = ram_rdata[SUM_W-1:0];

	assign vs_sum = {old_vs[SUM_W-1], old_vs} + {{(SUM_W-31){val_q[31]}}, val_q};
	assign ws_sum = {1'b0, old_ws} + (SUM_W+1)'(wgt_q);

	always_comb begin
		if (!touched_q[idx_q]) begin
			new_vs = {{(SUM_W-32){val_q[31]}}, val_q};
			new_ws = SUM_W'(wgt_q);
		end else begin
			if (vs_sum[SUM_W] != vs_sum[SUM_W-1]) begin
				new_vs = vs_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
				                       : {1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				new_vs = vs_sum[SUM_W-1:0];
			end
			new_ws = ws_sum[SUM_W] ? {SUM_W{1'b1}} : ws_sum[SUM_W-1:0];
		end
	end

	assign ram_wdata = {new_vs, new_ws};

	assign mag      = old_vs[SUM_W-1] ? (~old_vs + SUM_W'(1)) : old_vs;
	assign dividend = {mag, {FRAC_W{1'b0}}} + DVD_W'(old_ws >> 1);

	sdwa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (old_ws),
		.done    (div_done),
		.quotient(quo)
	);

	always_comb begin
		if (neg_q) begin
			if ((|quo[DVD_W-1:32]) || (quo[31] && (|quo[30:0]))) begin
				div_val = Q_MIN;
			end else begin
				div_val = ~quo[31:0] + 32'd1;
			end
		end else begin
			div_val = (|quo[DVD_W-1:31]) ? Q_MAX : quo[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (item.operation == OP_EMIT) ? S_EMIT_RD : S_ADD;
				end
			end
			S_ADD: begin
				state_d = S_IDLE;
			end
			S_EMIT_RD: begin
				if (touched_q[pos_q]) begin
					state_d = S_EMIT_CHK;
				end else if (pos_last) begin
					state_d = S_IDLE;
				end
			end
			S_EMIT_CHK: begin
				if (old_ws == '0) begin
					state_d = pos_last ? S_IDLE : S_EMIT_RD;
				end else begin
					state_d = S_EMIT_DIV;
				end
			end
			S_EMIT_DIV: begin
				if (div_done) begin
					state_d = pos_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		div_start = 1'b0;
		res_load  = 1'b0;
		pos_inc   = 1'b0;
		marks_clr = 1'b0;
		mark_set  = 1'b0;
		res_d.position    = POS_W'(pos_q);
		res_d.dense_value = '0;
		res_d.untouched   = 1'b0;
		res_d.status      = ST_OK;
		res_d.last        = pos_last;
		case (state_q)
			S_ADD: begin
				res_load          = 1'b1;
				res_d.position    = '0;
				res_d.last        = 1'b1;
				if (in_range_q) begin
					ram_we   = 1'b1;
					mark_set = 1'b1;
				end else begin
					res_d.status = ST_RANGE;
				end
			end
			S_EMIT_RD: begin
				if (!touched_q[pos_q]) begin
					res_load          = 1'b1;
					res_d.dense_value = fill_q;
					res_d.untouched   = 1'b1;
					pos_inc           = 1'b1;
					marks_clr         = pos_last;
				end
			end
			S_EMIT_CHK: begin
				if (old_ws == '0) begin
					res_load     = 1'b1;
					res_d.status = ST_ZERO_WEIGHT;
					if (old_vs[SUM_W-1]) begin
						res_d.dense_value = Q_MIN;
					end else if (old_vs != '0) begin
						res_d.dense_value = Q_MAX;
					end
					pos_inc   = 1'b1;
					marks_clr = pos_last;
				end else begin
					div_start = 1'b1;
				end
			end
			S_EMIT_DIV: begin
				if (div_done) begin
					res_load          = 1'b1;
					res_d.dense_value = div_val;
					pos_inc           = 1'b1;
					marks_clr         = pos_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pos_q          <= '0;
			touched_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= res_load;
			if (accept) begin
				pos_q <= '0;
			end else if (pos_inc) begin
				pos_q <= pos_q + IDX_W'(1);
			end
			if (marks_clr) begin
				touched_q <= '0;
			end else if (mark_set) begin
				touched_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Accepted item did not make the block busy.");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (in_range_q && state_q == S_ADD))
		else $error("RAM written for an out-of-range entry.");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_EMIT_DIV))
		else $error("Divider finished outside of the divide wait.");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> !busy)
		else $error("Final beat of an item shown while still busy.");

	a_marks_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q) != S_IDLE && $past(state_q) != S_ADD)
		|-> (touched_q == '0))
		else $error("Touched marks not cleared after an emit.");
`endif

endmodule

// File: tb/tb_sparse_to_dense_weighted_average_top.sv
`timescale 1ns / 1ps
// Self-checking testbench that drives entries and emits and checks every result beat.
module tb_sparse_to_dense_weighted_average_top;
	import sdwa_pkg::*;

	localparam int RUN_LIMIT = 5_000_000;
	localparam int RANDOM_ITEMS = 24;
	localparam int SAT_ADDS = 258;
	localparam longint VSUM_MAX = 64'sh0000_007F_FFFF_FFFF;
	localparam longint VSUM_MIN = -64'sh0000_0080_0000_0000;
	localparam longint unsigned WSUM_MAX = 64'h0000_00FF_FFFF_FFFF;
	localparam result_t ADD_OK = '{position: '0, dense_value: '0, untouched: 1'b0,
		status: ST_OK, last: 1'b1};
	localparam result_t ADD_RANGE = '{position: '0, dense_value: '0, untouched: 1'b0,
		status: ST_RANGE, last: 1'b1};

	typedef struct {
		int      grp;
		item_t   it;
		bit      chk;
		result_t want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	item_t      item;
	logic       result_valid;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_index_t cfg_index;
	logic [31:0] cfg_data;

	logic [6:0]  size_reg = 7'd64;
	logic [1:0]  sel_reg = 2'd0;
	logic [31:0] fill_reg = '0;
	longint          acc_value [DENSE_DEPTH];
	longint unsigned acc_weight [DENSE_DEPTH];
	bit              acc_touched [DENSE_DEPTH];
	result_t         awaited[$];
	stim_row_t       directed[$];

	logic [6:0]  dir_size [4] = '{7'd64, 7'd0, 7'd127, 7'd2};
	logic [1:0]  dir_sel [4] = '{2'd0, 2'd3, 2'd2, 2'd1};
	logic [31:0] dir_fill [4] = '{32'd0, Q_MIN, Q_MAX, 32'h0001_8000};

	int          errors = 0;
	int          burst_left = 0;
	int unsigned cycle_count = 0;

	sparse_to_dense_weighted_average_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result_valid(result_valid),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int eff_size();
		if (size_reg == 0) return 1;
		if (size_reg > DENSE_DEPTH) return DENSE_DEPTH;
		return int'(size_reg);
	endfunction

	function automatic logic [31:0] weighted_mean(input longint vs, input longint unsigned ws,
			output logic [1:0] st);
		logic [63:0] mag;
		logic [63:0] q;
		if (ws == 0) begin
			st = ST_ZERO_WEIGHT;
			if (vs > 0) return Q_MAX;
			if (vs < 0) return Q_MIN;
			return '0;
		end
		st = ST_OK;
		mag = (vs < 0) ? -vs : vs;
		q = ((mag << FRAC_W) + (ws >> 1)) / ws;
		if (vs < 0) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			q = -q;
		end else if (q > 64'h7FFF_FFFF) begin
			q = 64'h7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	task automatic accept_item(input item_t it);
		int n;
		int ix;
		logic [31:0] raw;
		longint v;
		longint s;
		longint unsigned ws;
		logic [1:0] st;
		result_t r;
		n = eff_size();
		if (it.operation == OP_ADD) begin
			ix = int'(it.entry_index);
			if (ix >= n) begin
				awaited.insert(awaited.size(), ADD_RANGE);
				return;
			end
			case (sel_reg)
				2'd0: raw = it.value_a;
				2'd1: raw = it.value_b;
				2'd2: raw = it.value_c;
				default: raw = it.value_d;
			endcase
			v = longint'($signed(raw));
			if (!acc_touched[ix]) begin
				acc_value[ix] = v;
				acc_weight[ix] = 64'(it.entry_weight);
				acc_touched[ix] = 1'b1;
			end else begin
				s = acc_value[ix] + v;
				if (s > VSUM_MAX) s = VSUM_MAX;
				if (s < VSUM_MIN) s = VSUM_MIN;
				acc_value[ix] = s;
				ws = acc_weight[ix] + it.entry_weight;
				if (ws > WSUM_MAX) ws = WSUM_MAX;
				acc_weight[ix] = ws;
			end
			awaited.insert(awaited.size(), ADD_OK);
		end else begin
			for (int p = 0; p < n; p++) begin
				r.position = POS_W'(p);
				r.last = (p == n - 1);
				if (acc_touched[p]) begin
					r.dense_value = weighted_mean(acc_value[p], acc_weight[p], st);
					r.untouched = 1'b0;
					r.status = st;
				end else begin
					r.dense_value = fill_reg;
					r.untouched = 1'b1;
					r.status = ST_OK;
				end
				awaited.insert(awaited.size(), r);
			end
			for (int p = 0; p < DENSE_DEPTH; p++) acc_touched[p] = 1'b0;
		end
	endtask

	function automatic logic [31:0] rand_q();
		logic [31:0] m;
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return 32'hFFFF_FFFF;
			4: begin
				m = $urandom_range(0, 32'h0008_0000);
				return $urandom_range(0, 1) ? -m : m;
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd1;
			3, 4: return $urandom_range(32'h0000_4000, 32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t make_item(input logic op, input logic [15:0] idx,
			input logic [1:0] sel, input logic [31:0] val, input logic [31:0] w);
		item_t it;
		it.operation = op;
		it.entry_index = idx;
		it.value_a = $urandom;
		it.value_b = $urandom;
		it.value_c = $urandom;
		it.value_d = $urandom;
		it.entry_weight = w;
		case (sel)
			2'd0: it.value_a = val;
			2'd1: it.value_b = val;
			2'd2: it.value_c = val;
			default: it.value_d = val;
		endcase
		return it;
	endfunction

	task automatic put_row(input int grp, input logic op, input logic [15:0] idx,
			input logic [31:0] val, input logic [31:0] w, input bit chk, input result_t want);
		stim_row_t row;
		row.grp = grp;
		row.it = make_item(op, idx, dir_sel[grp], val, w);
		row.chk = chk;
		row.want = want;
		directed.insert(directed.size(), row);
	endtask

	task automatic send_item(input item_t it);
		int gap_len;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_len > 0) begin
				start <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		accept_item(it);
	endtask

	task automatic drain();
		if (start) start <= 1'b0;
		while (awaited.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic set_config(input logic [6:0] sz, input logic [1:0] sel,
			input logic [31:0] fill);
		cfg_index_t idx [3];
		logic [31:0] dat [3];
		idx[0] = CFG_DENSE_SIZE;
		idx[1] = CFG_SEL_VAR;
		idx[2] = CFG_FILL;
		dat[0] = ($urandom & 32'hFFFF_FF80) | 32'(sz);
		dat[1] = ($urandom & 32'hFFFF_FFFC) | 32'(sel);
		dat[2] = fill;
		cfg_valid <= 1'b1;
		for (int k = 0; k < 3; k++) begin
			cfg_index <= idx[k];
			cfg_data <= dat[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		size_reg = sz;
		sel_reg = sel;
		fill_reg = fill;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing awaited, position %0d",
					result.position));
			end else begin
				want = awaited.pop_front();
				if (result.position !== want.position)
					report_mismatch($sformatf("position %0d, want %0d",
						result.position, want.position));
				if (result.dense_value !== want.dense_value)
					report_mismatch($sformatf("dense_value %h, want %h at position %0d",
						result.dense_value, want.dense_value, want.position));
				if (result.untouched !== want.untouched)
					report_mismatch($sformatf("untouched %b, want %b at position %0d",
						result.untouched, want.untouched, want.position));
				if (result.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d at position %0d",
						result.status, want.status, want.position));
				if (result.last !== want.last)
					report_mismatch($sformatf("last %b, want %b at position %0d",
						result.last, want.last, want.position));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int cur_grp;
		int sent;
		int n;
		int ph_len;
		int r;
		logic [6:0] sz;
		item_t it;
		start <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_DENSE_SIZE;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		put_row(0, OP_ADD, 16'd64, 32'h0001_0000, 32'h0001_0000, 1, ADD_RANGE);
		put_row(0, OP_ADD, 16'hFFFF, 32'h0001_0000, 32'h0001_0000, 1, ADD_RANGE);
		put_row(0, OP_EMIT, 16'd0, 32'd0, 32'd0, 0, '0);
		put_row(0, OP_ADD, 16'd0, Q_MAX, 32'd1, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd1, Q_MIN, 32'd1, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd2, 32'h0001_0000, 32'd0, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd3, 32'hFFFF_0000, 32'd0, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd4, 32'd0, 32'd0, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd5, 32'h0003_0000, 32'h0002_0000, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd6, 32'd1, 32'h0002_0000, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd7, 32'hFFFF_FFFF, 32'h0002_0000, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd63, Q_MAX, 32'hFFFF_FFFF, 1, ADD_OK);
		put_row(0, OP_ADD, 16'd5, 32'h0001_0000, 32'h0001_0000, 1, ADD_OK);
		put_row(0, OP_EMIT, 16'hFFFF, 32'd0, 32'd0, 0, '0);
		put_row(1, OP_EMIT, 16'd0, 32'd0, 32'd0, 1, '{6'd0, Q_MIN, 1'b1, ST_OK, 1'b1});
		put_row(1, OP_ADD, 16'd1, 32'h0005_0000, 32'h0001_0000, 1, ADD_RANGE);
		put_row(1, OP_ADD, 16'd0, 32'h0005_0000, 32'h0001_0000, 1, ADD_OK);
		put_row(1, OP_EMIT, 16'd0, 32'd0, 32'd0, 1,
			'{6'd0, 32'h0005_0000, 1'b0, ST_OK, 1'b1});
		put_row(2, OP_ADD, 16'd63, 32'hFFFE_0000, 32'h0000_8000, 1, ADD_OK);
		put_row(2, OP_ADD, 16'd64, 32'hFFFE_0000, 32'h0000_8000, 1, ADD_RANGE);
		put_row(2, OP_EMIT, 16'd0, 32'd0, 32'd0, 0, '0);
		put_row(3, OP_ADD, 16'd1, 32'h0004_0000, 32'd0, 1, ADD_OK);
		put_row(3, OP_ADD, 16'd0, 32'hFFFF_8000, 32'h0003_0000, 1, ADD_OK);
		put_row(3, OP_ADD, 16'd2, 32'hFFFF_8000, 32'h0003_0000, 1, ADD_RANGE);
		put_row(3, OP_EMIT, 16'd0, 32'd0, 32'd0, 0, '0);

		cur_grp = 0;
		foreach (directed[k]) begin
			if (directed[k].grp != cur_grp) begin
				cur_grp = directed[k].grp;
				drain();
				set_config(dir_size[cur_grp], dir_sel[cur_grp], dir_fill[cur_grp]);
			end
			send_item(directed[k].it);
			if (directed[k].chk) awaited[$] = directed[k].want;
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			case ($urandom_range(0, 19))
				0: sz = 7'd0;
				1: sz = 7'd1;
				2: sz = 7'd127;
				3: sz = 7'd64;
				4: sz = 7'($urandom_range(65, 126));
				5: sz = 7'($urandom_range(9, 63));
				default: sz = 7'($urandom_range(2, 8));
			endcase
			set_config(sz, 2'($urandom_range(0, 3)), rand_q());
			n = eff_size();
			ph_len = (n > 8) ? $urandom_range(6, 14) : $urandom_range(8, 30);
			for (int k = 0; k < ph_len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 4) drain();
				if (k == ph_len - 1 || r < 10)
					it = make_item(OP_EMIT, 16'($urandom), 2'($urandom), rand_q(),
						rand_weight());
				else if (r < 20)
					it = make_item(OP_ADD, 16'($urandom_range(n, 65535)), 2'($urandom),
						rand_q(), rand_weight());
				else
					it = make_item(OP_ADD, 16'($urandom_range(0, n - 1)), sel_reg,
						rand_q(), rand_weight());
				send_item(it);
				sent++;
			end
		end

		// Enough full-scale adds to one position to drive both sums into saturation.
		drain();
		set_config(7'd1, 2'($urandom_range(0, 3)), rand_q());
		for (int k = 0; k < SAT_ADDS; k++)
			send_item(make_item(OP_ADD, 16'd0, sel_reg, Q_MAX, 32'hFFFF_FFFF));
		send_item(make_item(OP_EMIT, 16'd0, sel_reg, 32'd0, 32'd0));

		drain();
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
design/sdwa_pkg.sv
design/sdwa_ram.sv
design/sdwa_div.sv
design/sparse_to_dense_weighted_average_top.sv
tb/tb_sparse_to_dense_weighted_average_top.sv
